// File: rtl/core/cet_pkg.sv
// Package: types, codes and constants shared by the transcoder modules.
package cet_pkg;

  localparam int UNIT_W  = 16;
  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  localparam logic [7:0] REPL_CHAR = 8'hBF;
  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] LEAD3     = 8'hE0;

  typedef enum logic [2:0] {
    MODE_L1_UTF8   = 3'd0,
    MODE_UTF8_L1   = 3'd1,
    MODE_UCS2_L1   = 3'd2,
    MODE_UCS2_UTF8 = 3'd3,
    MODE_UTF8_UCS2 = 3'd4,
    MODE_L1_UCS2   = 3'd5
  } mode_t;

  typedef struct packed {
    logic [MAX_RES-1:0][UNIT_W-1:0] unit;
    logic [1:0]                     cnt;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/cet_front.sv
// Front end: mode register, pending UTF-8 state, per-word result packet.
module cet_front import cet_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  input  logic              accept,
  input  logic [UNIT_W-1:0] in_unit,
  input  logic              in_last,
  output logic              pkt_push,
  output pkt_t              pkt
);

  logic [2:0]        mode_r;
  logic [7:0]        lead_r, lead_nxt;
  logic [1:0]        need_r, need_nxt;
  logic [UNIT_W-1:0] gath_r, gath_nxt;
  logic [7:0]        b;
  logic [15:0]       u;
  logic [UNIT_W-1:0] v2;

  assign u  = in_unit;
  assign b  = in_unit[7:0];
  assign v2 = {5'd0, lead_r[4:0], b[5:0]};

  always_comb begin
    lead_nxt = lead_r;
    need_nxt = need_r;
    gath_nxt = gath_r;
    pkt      = '0;
    case (mode_r)
      MODE_L1_UTF8: begin
        if (b[7]) begin
          pkt.unit[0] = {8'd0, LEAD2 | {6'd0, b[7:6]}};
          pkt.unit[1] = {8'd0, CONT_MARK | {2'd0, b[5:0]}};
          pkt.cnt     = 2'd2;
        end else begin
          pkt.unit[0] = {8'd0, b};
          pkt.cnt     = 2'd1;
        end
      end
      MODE_UTF8_L1: begin
        pkt.cnt = 2'd1;
        if (need_r != 2'd0) begin
          pkt.unit[0] = v2;
          lead_nxt = '0;
          need_nxt = '0;
          gath_nxt = '0;
        end else if (!b[7]) begin
          pkt.unit[0] = {8'd0, b};
        end else if (b inside {[8'hC0:8'hC3]} && !in_last) begin
          lead_nxt = b;
          need_nxt = 2'd1;
          pkt.cnt  = 2'd0;
        end else begin
          pkt.unit[0] = {8'd0, REPL_CHAR};
        end
      end
      MODE_UCS2_L1: begin
        pkt.unit[0] = (u > 16'd255) ? {8'd0, REPL_CHAR} : u;
        pkt.cnt     = 2'd1;
      end
      MODE_UCS2_UTF8: begin
        if (u <= 16'h007F) begin
          pkt.unit[0] = u;
          pkt.cnt     = 2'd1;
        end else if (u <= 16'h07FF) begin
          pkt.unit[0] = {8'd0, LEAD2 | {3'd0, u[10:6]}};
          pkt.unit[1] = {8'd0, CONT_MARK | {2'd0, u[5:0]}};
          pkt.cnt     = 2'd2;
        end else begin
          pkt.unit[0] = {8'd0, LEAD3 | {4'd0, u[15:12]}};
          pkt.unit[1] = {8'd0, CONT_MARK | {2'd0, u[11:6]}};
          pkt.unit[2] = {8'd0, CONT_MARK | {2'd0, u[5:0]}};
          pkt.cnt     = 2'd3;
        end
      end
      MODE_UTF8_UCS2: begin
        if (need_r == 2'd1) begin
          if (lead_r >= 8'hF0) begin
            pkt.unit[0] = '0;
          end else if (lead_r >= 8'hE0) begin
            pkt.unit[0] = gath_r | {10'd0, b[5:0]};
          end else begin
            pkt.unit[0] = v2;
          end
          pkt.cnt  = 2'd1;
          lead_nxt = '0;
          need_nxt = '0;
          gath_nxt = '0;
        end else begin
          if (need_r != 2'd0) begin
            if (need_r == 2'd2 && lead_r < 8'hF0) begin
              gath_nxt = gath_r | {4'd0, b[5:0], 6'd0};
            end
            need_nxt = need_r - 2'd1;
          end else if (!b[7]) begin
            pkt.unit[0] = {8'd0, b};
            pkt.cnt     = 2'd1;
          end else if (b inside {[8'hC2:8'hDF]}) begin
            lead_nxt = b;
            need_nxt = 2'd1;
          end else if (b inside {[8'hE0:8'hEF]}) begin
            lead_nxt = b;
            need_nxt = 2'd2;
            gath_nxt = {b[3:0], 12'd0};
          end else if (b inside {[8'hF0:8'hF3]}) begin
            lead_nxt = b;
            need_nxt = 2'd3;
            gath_nxt = '0;
          end
          if (in_last) begin
            lead_nxt = '0;
            need_nxt = '0;
            gath_nxt = '0;
          end
        end
      end
      MODE_L1_UCS2: begin
        pkt.unit[0] = {8'd0, b};
        pkt.cnt     = 2'd1;
      end
      default: begin
        pkt.cnt = 2'd0;
      end
    endcase
  end

  assign pkt_push = accept && (pkt.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_L1_UTF8;
      lead_r <= '0;
      need_r <= '0;
      gath_r <= '0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      lead_r <= '0;
      need_r <= '0;
      gath_r <= '0;
    end else if (accept) begin
      lead_r <= lead_nxt;
      need_r <= need_nxt;
      gath_r <= gath_nxt;
    end
  end

endmodule

// File: rtl/core/cet_queue.sv
// Packet queue between front end and serializer.
module cet_queue import cet_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  pkt_t    wr_pkt,
  input  logic    rd_en,
  output pkt_t    rd_pkt,
  output q_stat_t stat
);

  pkt_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_pkt     = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_pkt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/cet_back.sv
// Back end: serializes queued packets into the output word register.
module cet_back import cet_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pkt_t              head,
  input  q_stat_t           qstat,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [UNIT_W-1:0] out_unit,
  output logic              out_run_last
);

  logic              valid_r, valid_nxt;
  logic [UNIT_W-1:0] unit_r;
  logic              last_r;
  logic [1:0]        idx_r, idx_nxt;
  logic              load, is_end;

  assign load   = !qstat.empty && (!valid_r || pop);
  assign is_end = (idx_r == head.cnt - 2'd1);
  assign q_pop  = load && is_end;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_end ? 2'd0 : idx_r + 2'd1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unit_r <= head.unit[idx_r];
      last_r <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign empty        = !valid_r;
  assign out_unit     = unit_r;
  assign out_run_last = last_r;

  a_idx_in_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    !qstat.empty |-> (idx_r < head.cnt))
    else $error("serializer index beyond packet");

  a_mid_pkt_held: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> !qstat.empty)
    else $error("packet left queue before all words sent");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (valid_r && last_r))
    else $error("final word of packet not flagged");

endmodule

// File: rtl/core/character_encoding_transcoder.sv
// Top level: streaming UTF-8 / Latin-1 / UCS-2 transcoder.
// Usage:
//   Input is a queue write port: a word (in_unit, in_last) is taken at a
//   clock edge with push high and full low. Results are a queue read port:
//   while empty is low, out_unit/out_run_last hold the oldest result, taken
//   at an edge with pop high. out_run_last flags the final result of a word.
//   cfg_we/cfg_wdata set the conversion mode and clear any pending sequence;
//   write it only while idle.
// Path: a taken word is queued as a packet, then serialized into the output register.
// Throughput: one word per cycle when each word yields one result and pop
//   is high; the serializer emits one result per cycle while pop is high,
//   so a word with k results holds the output until all k are taken. A
//   four-packet queue between the front end and the serializer absorbs such
//   bursts; words yielding no result use no queue slot.
// Reset: synchronous, active low; mode returns to Latin-1 to UTF-8, pending
//   state and queue are cleared, no result is shown.
// Stall: if pop stays low, the queue fills and full rises; nothing is lost.
module character_encoding_transcoder import cet_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  input  logic              push,
  output logic              full,
  input  logic [UNIT_W-1:0] in_unit,
  input  logic              in_last,
  output logic              empty,
  input  logic              pop,
  output logic [UNIT_W-1:0] out_unit,
  output logic              out_run_last
);

  logic    accept, pkt_push, q_pop;
  pkt_t    pkt, head;
  q_stat_t qstat;

  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  cet_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_unit   (in_unit),
    .in_last   (in_last),
    .pkt_push  (pkt_push),
    .pkt       (pkt)
  );

  cet_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (pkt_push),
    .wr_pkt (pkt),
    .rd_en  (q_pop),
    .rd_pkt (head),
    .stat   (qstat)
  );

  cet_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .qstat        (qstat),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_unit     (out_unit),
    .out_run_last (out_run_last)
  );

endmodule

// File: sim/tb_character_encoding_transcoder.sv
// Testbench for the transcoder: directed and random words checked against a scoreboard.
module tb_character_encoding_transcoder import cet_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         IDLE_PCT     = 11;
  localparam logic [2:0] MODE_SPARE6  = 3'd6;
  localparam logic [2:0] MODE_SPARE7  = 3'd7;
  localparam int         NUM_PHASES   = 11;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              run_last;
  } unit_res_t;

  class word_scoreboard;
    logic [2:0]        mode;
    logic [7:0]        lead;
    logic [1:0]        need;
    logic [UNIT_W-1:0] gath;
    unit_res_t         expect_q[$];
    int                n_words;
    int                n_checked;
    int                n_errors;

    function new();
      mode      = MODE_L1_UTF8;
      n_words   = 0;
      n_checked = 0;
      n_errors  = 0;
      drop_partial();
    endfunction

    function void drop_partial();
      lead = '0;
      need = '0;
      gath = '0;
    endfunction

    function void set_mode(logic [2:0] m);
      mode = m;
      drop_partial();
    endfunction

    function int pending();
      return expect_q.size();
    endfunction

    function void flag_error(string msg);
      n_errors++;
      if (n_errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // utf8 decode into ucs2, continuation bytes are not validated
    function void decode_ucs2(logic [7:0] b, logic l, ref logic [UNIT_W-1:0] vals[$]);
      if (need != 0) begin
        if (need == 1) begin
          if (lead >= 8'hF0) vals.push_back('0);
          else if (lead >= LEAD3) vals.push_back(gath | {10'b0, b[5:0]});
          else vals.push_back({5'b0, lead[4:0], b[5:0]});
          drop_partial();
        end else begin
          if (need == 2 && lead < 8'hF0) gath = gath | {4'b0, b[5:0], 6'b0};
          need = need - 2'd1;
          if (l) drop_partial();
        end
      end else begin
        if (b <= 8'h7F) begin
          vals.push_back({8'h00, b});
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          lead = b;
          need = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          lead = b;
          need = 2'd2;
          gath = {b[3:0], 12'b0};
        end else if (b >= 8'hF0 && b <= 8'hF3) begin
          lead = b;
          need = 2'd3;
          gath = '0;
        end
        if (l) drop_partial();
      end
    endfunction

    function void note_word(logic [UNIT_W-1:0] u, logic l);
      logic [7:0]        b;
      logic [UNIT_W-1:0] vals[$];
      b = u[7:0];
      n_words++;
      case (mode)
        MODE_L1_UTF8: begin
          if (b > 8'h7F) begin
            vals.push_back({8'h00, 6'b110000, b[7:6]});
            vals.push_back({8'h00, 2'b10, b[5:0]});
          end else begin
            vals.push_back({8'h00, b});
          end
        end
        MODE_UTF8_L1: begin
          if (need != 0) begin
            vals.push_back({5'b0, lead[4:0], b[5:0]});
            drop_partial();
          end else if (b <= 8'h7F) begin
            vals.push_back({8'h00, b});
          end else if (b >= LEAD2 && b <= 8'hC3 && !l) begin
            lead = b;
            need = 2'd1;
          end else begin
            vals.push_back({8'h00, REPL_CHAR});
          end
        end
        MODE_UCS2_L1: begin
          vals.push_back(u > 16'h00FF ? {8'h00, REPL_CHAR} : u);
        end
        MODE_UCS2_UTF8: begin
          if (u <= 16'h007F) begin
            vals.push_back(u);
          end else if (u <= 16'h07FF) begin
            vals.push_back({8'h00, 3'b110, u[10:6]});
            vals.push_back({8'h00, 2'b10, u[5:0]});
          end else begin
            vals.push_back({8'h00, 4'hE, u[15:12]});
            vals.push_back({8'h00, 2'b10, u[11:6]});
            vals.push_back({8'h00, 2'b10, u[5:0]});
          end
        end
        MODE_UTF8_UCS2: decode_ucs2(b, l, vals);
        MODE_L1_UCS2:   vals.push_back({8'h00, b});
        default: ;
      endcase
      foreach (vals[i]) expect_q.push_back('{unit: vals[i], run_last: (i == vals.size() - 1)});
    endfunction

    function void check_result(logic [UNIT_W-1:0] u, logic rl);
      unit_res_t e;
      n_checked++;
      if (expect_q.size() == 0) begin
        flag_error($sformatf("unexpected result unit=%h run_last=%b", u, rl));
        return;
      end
      e = expect_q.pop_front();
      if (u !== e.unit || rl !== e.run_last)
        flag_error($sformatf("unit exp %h got %h, run_last exp %b got %b",
                             e.unit, u, e.run_last, rl));
    endfunction
  endclass

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [2:0]        cfg_wdata = '0;
  logic              push      = 1'b0;
  logic [UNIT_W-1:0] in_unit   = '0;
  logic              in_last   = 1'b0;
  logic              pop       = 1'b0;
  logic              full;
  logic              empty;
  logic [UNIT_W-1:0] out_unit;
  logic              out_run_last;

  word_scoreboard sb;
  bit             quiet     = 1'b0;
  bit             hold_req  = 1'b0;
  int             hold_left = 0;
  int             cycles    = 0;
  int             n_modes   = 0;

  logic [2:0] phase_mode [NUM_PHASES] = '{MODE_UCS2_UTF8, MODE_UTF8_L1, MODE_UTF8_UCS2,
                                          MODE_L1_UTF8, MODE_L1_UCS2, MODE_UCS2_L1,
                                          MODE_SPARE6, MODE_UTF8_UCS2, MODE_SPARE7,
                                          MODE_UTF8_L1, MODE_UCS2_UTF8};
  int         phase_len  [NUM_PHASES] = '{25, 25, 30, 20, 40, 20, 6, 25, 6, 20, 20};

  character_encoding_transcoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_unit      (in_unit),
    .in_last      (in_last),
    .empty        (empty),
    .pop          (pop),
    .out_unit     (out_unit),
    .out_run_last (out_run_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [UNIT_W-1:0] u, input logic l);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_unit <= u;
    in_last <= l;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_word(u, l);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [2:0] m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_mode(m);
    n_modes++;
  endtask

  function automatic logic [UNIT_W-1:0] rand_unit(input logic [2:0] m);
    if (m == MODE_UCS2_UTF8 || m == MODE_UCS2_L1) begin
      case ($urandom_range(3))
        0: return UNIT_W'($urandom_range(16'h00FF));
        1: return UNIT_W'($urandom_range(16'h07FF, 16'h0080));
        2: return UNIT_W'($urandom_range(16'hFFFF, 16'h0800));
        default: begin
          case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'h007F;
            2: return 16'h0080;
            3: return 16'h07FF;
            4: return 16'h0800;
            default: return 16'hFFFF;
          endcase
        end
      endcase
    end
    return UNIT_W'($urandom_range(16'hFFFF));
  endfunction

  // one utf8 character, or a noise byte; sometimes cut short by in_last
  task automatic send_utf8_char(input logic [2:0] m, inout int sent);
    logic [7:0] seq[$];
    logic [7:0] hi;
    int         len;
    int         cut;
    logic       fin;
    if ($urandom_range(99) < 20) begin
      seq.push_back(8'($urandom_range(255)));
    end else begin
      len = $urandom_range(1, 4);
      case (len)
        1: seq.push_back(8'($urandom_range(127)));
        2: begin
          if (m == MODE_UTF8_L1 && $urandom_range(1)) seq.push_back(LEAD2 | 8'($urandom_range(3)));
          else seq.push_back(LEAD2 | 8'($urandom_range(31)));
        end
        3: seq.push_back(LEAD3 | 8'($urandom_range(15)));
        default: seq.push_back(8'hF0 | 8'($urandom_range(3)));
      endcase
      for (int k = 1; k < len; k++) begin
        if ($urandom_range(9) == 0) seq.push_back(8'($urandom_range(255)));
        else seq.push_back(CONT_MARK | 8'($urandom_range(63)));
      end
    end
    fin = ($urandom_range(7) == 0);
    cut = (seq.size() > 1 && $urandom_range(9) == 0) ? $urandom_range(seq.size() - 2) : -1;
    foreach (seq[i]) begin
      hi = 8'($urandom_range(255));
      send_word({hi, seq[i]}, (i == seq.size() - 1) ? fin : (i == cut));
      sent++;
    end
  endtask

  task automatic send_random(input logic [2:0] m, input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if (m == MODE_UTF8_L1 || m == MODE_UTF8_UCS2) begin
        send_utf8_char(m, sent);
      end else begin
        send_word(rand_unit(m), $urandom_range(7) == 0);
        sent++;
      end
    end
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_result(out_unit, out_run_last);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mode is latin-1 to utf-8
    send_word(16'h0000, 1'b0);
    send_word(16'h0080, 1'b0);
    send_word(16'hFFFF, 1'b1);

    set_mode(MODE_UTF8_L1);
    send_word(16'hA5C3, 1'b0);
    send_word(16'h00FF, 1'b0);
    send_word(16'h00C0, 1'b1);
    send_word(16'h00C4, 1'b0);
    send_word(16'h007F, 1'b1);

    set_mode(MODE_UCS2_L1);
    send_word(16'h00FF, 1'b0);
    send_word(16'h0100, 1'b1);

    set_mode(MODE_UCS2_UTF8);
    send_word(16'h007F, 1'b0);
    send_word(16'h07FF, 1'b0);
    send_word(16'hFFFF, 1'b1);

    set_mode(MODE_UTF8_UCS2);
    send_word(16'h00E2, 1'b0);
    send_word(16'h0082, 1'b0);
    send_word(16'h00AC, 1'b0);
    send_word(16'h00F0, 1'b0);
    send_word(16'h009F, 1'b0);
    send_word(16'h0098, 1'b0);
    send_word(16'h0080, 1'b1);
    send_word(16'h0085, 1'b0);
    send_word(16'h00E1, 1'b0);
    send_word(16'h0080, 1'b1);
    send_word(16'h00E2, 1'b0);

    // mode write drops the partial sequence
    set_mode(MODE_UTF8_L1);
    send_word(16'h0085, 1'b1);

    set_mode(MODE_L1_UCS2);
    send_word(16'hFFFF, 1'b1);

    set_mode(MODE_SPARE6);
    send_word(16'h1234, 1'b0);
    set_mode(MODE_SPARE7);
    send_word(16'h00C3, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode(phase_mode[p]);
      quiet = (phase_mode[p] == MODE_L1_UCS2);
      if (p == 0) hold_req = 1'b1;
      send_random(phase_mode[p], phase_len[p]);
      quiet = 1'b0;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Ran %0d words through %0d mode writes, all six modes and both unused codes,",
             sb.n_words, n_modes);
    $display("checking %0d results under random stalls and one long output hold-off.",
             sb.n_checked);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
